### sv/escape_time_fractal_pixel_macros.svh
// Assertion macros shared by the fractal pixel modules.
// Each macro expects clk and arst_n in scope.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ETFP_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("fractal pixel check failed");
// next-cycle implication
`define ETFP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fractal pixel check failed");
`else
`define ETFP_ASSERT_IMP(lbl, pre, post)
`define ETFP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### sv/etfp_pkg.sv
package etfp_pkg;

	// fixed point format
	localparam int FRAC_BITS = 28;
	localparam int Q_W       = 32;
	localparam int Z_W       = 34;
	localparam int MUL_W     = 31;
	localparam int PROD_W    = 60;

	// pixel mapping
	localparam int PIX_W      = 10;
	localparam int IMAGE_SIZE = 1024;
	localparam int HALF_SIZE  = IMAGE_SIZE / 2;
	localparam int OFF_W      = PIX_W + 2;
	localparam int STEP_W     = 31;
	localparam int MAP_W      = OFF_W + STEP_W + 1;
	localparam int MAP_SUM_W  = MAP_W + 1;

	// counts
	localparam int CNT_W  = 16;
	localparam int MAXF_W = 17;
	localparam int COL_W  = 8;

	// color scaling: 256*count divided by radix powers
	localparam int COLOR_RADIX = 30;
	localparam int SUM_W       = CNT_W + 8;
	localparam int RECIP_W     = SUM_W + 1;
	localparam int CPROD_W     = SUM_W + RECIP_W;
	localparam longint unsigned RAD1 = COLOR_RADIX;
	localparam longint unsigned RAD2 = RAD1 * RAD1;
	localparam longint unsigned RAD3 = RAD2 * RAD1;
	localparam int SHIFT1 = SUM_W + $clog2(RAD1);
	localparam int SHIFT2 = SUM_W + $clog2(RAD2);
	localparam int SHIFT3 = SUM_W + $clog2(RAD3);
	localparam logic [RECIP_W-1:0] RECIP1 =
		RECIP_W'(((64'd1 << SHIFT1) + RAD1 - 64'd1) / RAD1);
	localparam logic [RECIP_W-1:0] RECIP2 =
		RECIP_W'(((64'd1 << SHIFT2) + RAD2 - 64'd1) / RAD2);
	localparam logic [RECIP_W-1:0] RECIP3 =
		RECIP_W'(((64'd1 << SHIFT3) + RAD3 - 64'd1) / RAD3);

	// register file
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	typedef enum logic [1:0] {
		REG_CENTER_RE,
		REG_CENTER_IM,
		REG_PIXEL_STEP,
		REG_MAX_ITER
	} reg_idx_t;

	localparam logic signed [Q_W-1:0] CENTER_RE_RST  = -32'sd152471339;
	localparam logic signed [Q_W-1:0] CENTER_IM_RST  = -32'sd152202904;
	localparam logic [STEP_W-1:0]     PIXEL_STEP_RST = 31'd10737;
	localparam logic [CNT_W-1:0]      MAX_ITER_RST   = 16'd27000;

	typedef struct packed {
		logic signed [Q_W-1:0] center_re;
		logic signed [Q_W-1:0] center_im;
		logic [STEP_W-1:0]     pixel_step;
		logic [CNT_W-1:0]      max_iterations;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic map_mul;
		logic map_add;
		logic mul;
		logic step;
		logic esc_done;
		logic lim_done;
		logic color;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_limit;
		logic escaped;
		logic last;
	} status_t;

endpackage

### sv/escape_time_fractal_pixel.sv
// Escape-time fractal pixel engine.
// Request channel: pixel_x/pixel_y with pix_valid/pix_ready. Each request maps
// the pixel to c = center + (pixel - 512) * pixel_step in Q4.28 and iterates
// z = z*z + c from z = c until |z| > 2 or the iteration limit is hit.
// Result channel: escape_count, in_set, red, green, blue, max_finite with
// res_valid/res_ready; one result per request, in order.
// Configuration: APB-style registers center_re, center_im, pixel_step and
// max_iterations at byte addresses 0, 4, 8, 12; write only while idle.
// Timing: one request at a time. A request passes through ST_MAP, then ST_MUL
// and ST_ADD for each iteration (multiply on the complex squaring unit, then
// add and escape test), then ST_COLOR and ST_FIN. res_valid rises as the
// engine returns to idle, and the next request can be taken from then on.
// A finished result sits in an output register; a new request is accepted
// while it waits. If the receiver stalls, the engine holds the next result
// in its last stage until the register frees up.
// Reset: registers return to their defaults, the running maximum to -1,
// and both channels go empty.
module escape_time_fractal_pixel (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  logic [etfp_pkg::PIX_W-1:0]         pixel_x,
	input  logic [etfp_pkg::PIX_W-1:0]         pixel_y,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [etfp_pkg::CNT_W-1:0]         escape_count,
	output logic                               in_set,
	output logic [etfp_pkg::COL_W-1:0]         red,
	output logic [etfp_pkg::COL_W-1:0]         green,
	output logic [etfp_pkg::COL_W-1:0]         blue,
	output logic signed [etfp_pkg::MAXF_W-1:0] max_finite,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [etfp_pkg::ADDR_W-1:0]        paddr,
	input  logic [etfp_pkg::DATA_W-1:0]        pwdata,
	output logic [etfp_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import etfp_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// configuration registers
	etfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	etfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic
	etfp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.cmd          (cmd),
		.status       (status),
		.escape_count (escape_count),
		.in_set       (in_set),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.max_finite   (max_finite)
	);

endmodule

### sv/etfp_cfg.sv
module etfp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [etfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [etfp_pkg::DATA_W-1:0]  pwdata,
	output logic [etfp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output etfp_pkg::cfg_t               cfg
);
	import etfp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_re      <= CENTER_RE_RST;
			cfg_q.center_im      <= CENTER_IM_RST;
			cfg_q.pixel_step     <= PIXEL_STEP_RST;
			cfg_q.max_iterations <= MAX_ITER_RST;
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_RE:  cfg_q.center_re      <= $signed(pwdata);
				REG_CENTER_IM:  cfg_q.center_im      <= $signed(pwdata);
				REG_PIXEL_STEP: cfg_q.pixel_step     <= pwdata[STEP_W-1:0];
				REG_MAX_ITER:   cfg_q.max_iterations <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_CENTER_RE:  prdata = cfg_q.center_re;
			REG_CENTER_IM:  prdata = cfg_q.center_im;
			REG_PIXEL_STEP: prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_q.pixel_step};
			REG_MAX_ITER:   prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_q.max_iterations};
			default:        prdata = '0;
		endcase
	end

endmodule

### sv/etfp_ctrl.sv
`include "escape_time_fractal_pixel_macros.svh"

module etfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  etfp_pkg::status_t status,
	output etfp_pkg::cmd_t    cmd
);
	import etfp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_MUL,
		ST_ADD,
		ST_COLOR,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   res_valid_q;

	assign pix_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

	// commands per state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.map_mul = pix_valid;
			ST_MAP: begin
				cmd.map_add  = 1'b1;
				cmd.lim_done = status.zero_limit;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_ADD: begin
				if (status.escaped) begin
					cmd.esc_done = 1'b1;
				end else if (status.last) begin
					cmd.lim_done = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_COLOR: cmd.color = 1'b1;
			ST_FIN: cmd.out_load = !res_valid_q || res_ready;
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (pix_valid) state_q <= ST_MAP;
				ST_MAP: state_q <= status.zero_limit ? ST_COLOR : ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= cmd.step ? ST_MUL : ST_COLOR;
				ST_COLOR: state_q <= ST_FIN;
				ST_FIN: if (cmd.out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ETFP_ASSERT_NEXT(a_load_shows, cmd.out_load, res_valid_q)
	`ETFP_ASSERT_IMP(a_no_overwrite, cmd.out_load, !res_valid_q || res_ready)
	`ETFP_ASSERT_IMP(a_one_exit, state_q == ST_ADD, $onehot({cmd.esc_done, cmd.lim_done, cmd.step}))

endmodule

### sv/etfp_dp.sv
`include "escape_time_fractal_pixel_macros.svh"

module etfp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  etfp_pkg::cfg_t                     cfg,
	input  logic [etfp_pkg::PIX_W-1:0]         pixel_x,
	input  logic [etfp_pkg::PIX_W-1:0]         pixel_y,
	input  etfp_pkg::cmd_t                     cmd,
	output etfp_pkg::status_t                  status,
	output logic [etfp_pkg::CNT_W-1:0]         escape_count,
	output logic                               in_set,
	output logic [etfp_pkg::COL_W-1:0]         red,
	output logic [etfp_pkg::COL_W-1:0]         green,
	output logic [etfp_pkg::COL_W-1:0]         blue,
	output logic signed [etfp_pkg::MAXF_W-1:0] max_finite
);
	import etfp_pkg::*;

	localparam logic signed [MAP_SUM_W-1:0] SAT_HI = (MAP_SUM_W'(1) <<< (Q_W - 1)) - 1;
	localparam logic signed [MAP_SUM_W-1:0] SAT_LO = -(MAP_SUM_W'(1) <<< (Q_W - 1));
	localparam logic signed [Z_W-1:0]       Z_TWO  = Z_W'(1) <<< (FRAC_BITS + 1);
	localparam logic signed [Z_W-1:0]       Z_NTWO = -Z_TWO;
	localparam logic [PROD_W:0]             MAG_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

	// clamp a mapped coordinate to Q4.28
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [MAP_SUM_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[Q_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	logic signed [OFF_W-1:0]     off_re, off_im;
	logic signed [STEP_W:0]      step_s;
	logic signed [MAP_W-1:0]     map_re_q, map_im_q;
	logic signed [Q_W-1:0]       cr_next, ci_next;
	logic signed [Q_W-1:0]       cr_q, ci_q;
	logic signed [Z_W-1:0]       zr_q, zi_q;
	logic signed [MUL_W-1:0]     a_r, a_i;
	logic signed [2*MUL_W-1:0]   sqr_full, sqi_full, px_full;
	logic [PROD_W-1:0]           sqr_q, sqi_q;
	logic signed [PROD_W-1:0]    px_q;
	logic [PROD_W:0]             mag;
	logic signed [PROD_W:0]      nr_diff, nr_sh;
	logic signed [PROD_W-1:0]    ni_sh;
	logic signed [Z_W-1:0]       nr_next, ni_next;
	logic                        oob;
	logic [CNT_W-1:0]            it_q;
	logic signed [MAXF_W-1:0]    it_ext;
	logic [CNT_W-1:0]            count_q;
	logic                        in_set_q;
	logic signed [MAXF_W-1:0]    max_q;
	logic [SUM_W-1:0]            scaled;
	logic [CPROD_W-1:0]          cp1, cp2, cp3;
	logic [COL_W-1:0]            red_q, green_q, blue_q;
	logic [CNT_W-1:0]            out_count_q;
	logic                        out_in_set_q;
	logic [COL_W-1:0]            out_red_q, out_green_q, out_blue_q;
	logic signed [MAXF_W-1:0]    out_max_q;

	// pixel offset from image center
	assign off_re = $signed({2'b00, pixel_x}) - $signed(OFF_W'(HALF_SIZE));
	assign off_im = $signed({2'b00, pixel_y}) - $signed(OFF_W'(HALF_SIZE));
	assign step_s = $signed({1'b0, cfg.pixel_step});

	// add center and saturate
	assign cr_next = sat_q(MAP_SUM_W'(map_re_q) + MAP_SUM_W'(cfg.center_re));
	assign ci_next = sat_q(MAP_SUM_W'(map_im_q) + MAP_SUM_W'(cfg.center_im));

	// complex squaring operands
	assign a_r      = $signed(zr_q[MUL_W-1:0]);
	assign a_i      = $signed(zi_q[MUL_W-1:0]);
	assign sqr_full = (2*MUL_W)'(a_r) * (2*MUL_W)'(a_r);
	assign sqi_full = (2*MUL_W)'(a_i) * (2*MUL_W)'(a_i);
	assign px_full  = (2*MUL_W)'(a_r) * (2*MUL_W)'(a_i);

	// escape test on current z
	assign oob = (zr_q > Z_TWO) || (zr_q < Z_NTWO) || (zi_q > Z_TWO) || (zi_q < Z_NTWO);
	assign mag = {1'b0, sqr_q} + {1'b0, sqi_q};

	// next z: floor-shifted products plus c
	assign nr_diff = $signed({1'b0, sqr_q}) - $signed({1'b0, sqi_q});
	assign nr_sh   = nr_diff >>> FRAC_BITS;
	assign ni_sh   = px_q >>> (FRAC_BITS - 1);
	assign nr_next = $signed(nr_sh[Z_W-1:0]) + Z_W'(cr_q);
	assign ni_next = $signed(ni_sh[Z_W-1:0]) + Z_W'(ci_q);

	assign it_ext = $signed({1'b0, it_q});

	assign status.zero_limit = (cfg.max_iterations == '0);
	assign status.escaped    = oob || (mag > MAG_LIMIT);
	assign status.last       = ({1'b0, it_q} + 1'b1) == {1'b0, cfg.max_iterations};

	// color scaling by reciprocal multiply
	assign scaled = {count_q, 8'h00};
	assign cp1    = CPROD_W'(scaled) * CPROD_W'(RECIP1);
	assign cp2    = CPROD_W'(scaled) * CPROD_W'(RECIP2);
	assign cp3    = CPROD_W'(scaled) * CPROD_W'(RECIP3);

	// iteration datapath
	always_ff @(posedge clk) begin
		if (cmd.map_mul) begin
			map_re_q <= MAP_W'(off_re) * MAP_W'(step_s);
			map_im_q <= MAP_W'(off_im) * MAP_W'(step_s);
		end
		if (cmd.map_add) begin
			cr_q <= cr_next;
			ci_q <= ci_next;
			zr_q <= Z_W'(cr_next);
			zi_q <= Z_W'(ci_next);
			it_q <= '0;
		end else if (cmd.step) begin
			zr_q <= nr_next;
			zi_q <= ni_next;
			it_q <= it_q + 1'b1;
		end
		if (cmd.mul) begin
			sqr_q <= sqr_full[PROD_W-1:0];
			sqi_q <= sqi_full[PROD_W-1:0];
			px_q  <= $signed(px_full[PROD_W-1:0]);
		end
		if (cmd.esc_done) begin
			count_q  <= it_q;
			in_set_q <= 1'b0;
		end else if (cmd.lim_done) begin
			count_q  <= cfg.max_iterations;
			in_set_q <= 1'b1;
		end
		if (cmd.color) begin
			blue_q  <= in_set_q ? '0 : cp1[SHIFT1 +: COL_W];
			red_q   <= in_set_q ? '0 : cp2[SHIFT2 +: COL_W];
			green_q <= in_set_q ? '0 : cp3[SHIFT3 +: COL_W];
		end
		if (cmd.out_load) begin
			out_count_q  <= count_q;
			out_in_set_q <= in_set_q;
			out_red_q    <= red_q;
			out_green_q  <= green_q;
			out_blue_q   <= blue_q;
			out_max_q    <= max_q;
		end
	end

	// running maximum of finite escape counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '1;
		end else if (cmd.esc_done && (it_ext > max_q)) begin
			max_q <= it_ext;
		end
	end

	assign escape_count = out_count_q;
	assign in_set       = out_in_set_q;
	assign red          = out_red_q;
	assign green        = out_green_q;
	assign blue         = out_blue_q;
	assign max_finite   = out_max_q;

	`ETFP_ASSERT_NEXT(a_max_covers, cmd.esc_done, max_q >= $past(it_ext))
	`ETFP_ASSERT_NEXT(a_limit_flag, cmd.lim_done, in_set_q && (count_q == $past(cfg.max_iterations)))

endmodule
